/* rtl/sha_pkg.sv */
// Package with SHA-256 constants, queue entry type and a rotate-right function.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  // One word for the core: pushed into the block, marks the end of a message.
  typedef struct packed {
    logic [31:0] word;
    logic        fin;
  } sha_entry_t;

  localparam int QDepth = 4;
  localparam int QIdxW  = 2;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: front end, word queue and compression core.
// A 16-word block is loaded from the queue, compressed at one round per cycle and added
// into the chaining value; the core pops no words during rounds, add or digest output, so it sets the rate.
// After the last word, padding takes 2 to 18 extra words, then eight digest transfers.
// Synchronous active-low reset restores the initial hash and clears all counters.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  logic       q_push, q_full, q_pop, q_nonempty;
  sha_entry_t q_entry, q_head;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_word, .in_valid_bytes, .in_last,
    .q_push, .q_entry, .q_full
  );

  sha_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_entry(q_entry), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .head(q_head)
  );

  sha_core u_core (
    .clk, .rst_n, .q_nonempty, .q_head, .q_pop, .out_valid, .out_stall,
    .out_digest_word, .out_word_index, .out_last_word
  );

endmodule
`default_nettype wire

/* rtl/sha_front.sv */
// Front end: tracks the bit length and expands the last word into padding words.
`timescale 1ns / 1ps
`default_nettype none
module sha_front import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_last,
  output logic             q_push,
  output sha_entry_t       q_entry,
  input  wire logic        q_full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_W80  = 3'd1;
  localparam logic [2:0] F_ZERO = 3'd2;
  localparam logic [2:0] F_LENH = 3'd3;
  localparam logic [2:0] F_LENL = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [2:0]  nb;
  logic [31:0] mask, padded;
  logic [5:0]  sh;

  assign nb = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
  assign sh = 6'd32 - {nb, 3'b000};
  assign mask = (nb == 3'd0) ? 32'd0 : (32'hffffffff << sh);
  assign padded = (in_data_word & mask) | (32'h80 << (6'd24 - {nb, 3'b000}));
  assign in_stall = (state_r != F_IDLE) || q_full;

  // Generate one queue transfer per cycle while the queue has room and, when idle, input is valid.
  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r;
    fill_nxt = fill_r;
    q_push = 1'b0;
    q_entry = '{word: 32'd0, fin: 1'b0};
    if (!q_full) begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            q_push = 1'b1;
            fill_nxt = fill_r + 4'd1;
            if (!in_last) begin
              len_nxt = len_r + 64'd32;
              q_entry.word = in_data_word;
            end else begin
              len_nxt = len_r + {58'd0, nb, 3'b000};
              if (nb == 3'd4) begin
                q_entry.word = in_data_word;
                state_nxt = F_W80;
              end else begin
                q_entry.word = padded;
                state_nxt = (fill_r + 4'd1 == 4'd14) ? F_LENH : F_ZERO;
              end
            end
          end
        end
        F_W80: begin
          q_push = 1'b1;
          q_entry.word = 32'h80000000;
          fill_nxt = fill_r + 4'd1;
          state_nxt = (fill_r + 4'd1 == 4'd14) ? F_LENH : F_ZERO;
        end
        F_ZERO: begin
          q_push = 1'b1;
          fill_nxt = fill_r + 4'd1;
          if (fill_r + 4'd1 == 4'd14) state_nxt = F_LENH;
        end
        F_LENH: begin
          q_push = 1'b1;
          q_entry.word = len_r[63:32];
          state_nxt = F_LENL;
        end
        F_LENL: begin
          q_push = 1'b1;
          q_entry.word = len_r[31:0];
          q_entry.fin = 1'b1;
          state_nxt = F_IDLE;
          len_nxt = 64'd0;
          fill_nxt = 4'd0;
        end
        default: state_nxt = F_IDLE;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      len_r <= 64'd0;
      fill_r <= 4'd0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/sha_queue.sv */
// Short word queue between the front end and the compression core.
`timescale 1ns / 1ps
`default_nettype none
module sha_queue import sha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  sha_entry_t push_entry,
  output logic      full,
  input  wire logic pop,
  output logic      nonempty,
  output sha_entry_t head
);

  sha_entry_t mem_r [QDepth];
  logic [QIdxW-1:0] wp_r, rp_r;
  logic [QIdxW:0]   cnt_r;

  assign full = (cnt_r == QDepth[QIdxW:0]);
  assign nonempty = (cnt_r != '0);
  assign head = mem_r[rp_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{QIdxW{1'b0}}, push} - {{QIdxW{1'b0}}, pop};
    end
  end

endmodule
`default_nettype wire

/* rtl/sha_core.sv */
// Back end: block buffer, one compression round per cycle, digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha_core import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_nonempty,
  input  sha_entry_t       q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  localparam logic [1:0] C_LOAD = 2'd0;
  localparam logic [1:0] C_RND  = 2'd1;
  localparam logic [1:0] C_ADD  = 2'd2;
  localparam logic [1:0] C_OUT  = 2'd3;

  logic [1:0]  state_r;
  logic [3:0]  fill_r;
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic [2:0]  oidx_r;
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] a2, a15, s0, s1, wnew, wcur, t1, t2, e, a;

  // Schedule and round datapath.
  always_comb begin
    a2 = w_r[rnd_r[3:0] - 4'd2];
    a15 = w_r[rnd_r[3:0] - 4'd15];
    s1 = rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10);
    s0 = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
    wnew = s1 + w_r[rnd_r[3:0] - 4'd7] + s0 + w_r[rnd_r[3:0]];
    wcur = (rnd_r >= 6'd16) ? wnew : w_r[rnd_r[3:0]];
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v_r[5]) ^ (~e & v_r[6]))
       + K_ROUND[rnd_r] + wcur;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) ^ 32'd0;
    t2 = t2 + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  assign q_pop = (state_r == C_LOAD) && q_nonempty;
  assign out_valid = (state_r == C_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);

  // Block buffer and working variables.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_r[fill_r] <= q_head.word;
      if (fill_r == 4'd15) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
    end
    if (state_r == C_RND) begin
      w_r[rnd_r[3:0]] <= wcur;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  // Sequencer and chaining value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_LOAD;
      fill_r <= 4'd0;
      rnd_r <= 6'd0;
      fin_r <= 1'b0;
      oidx_r <= 3'd0;
      for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
    end else begin
      case (state_r)
        C_LOAD: begin
          if (q_pop) begin
            fill_r <= fill_r + 4'd1;
            if (fill_r == 4'd15) begin
              fin_r <= q_head.fin;
              rnd_r <= 6'd0;
              state_r <= C_RND;
            end
          end
        end
        C_RND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= C_ADD;
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          oidx_r <= 3'd0;
          state_r <= fin_r ? C_OUT : C_LOAD;
        end
        C_OUT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
              state_r <= C_LOAD;
            end
          end
        end
        default: state_r <= C_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire
